[hdl/kpi_pkg.sv]
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types and constants of the keyframe pose interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

	localparam int unsigned CW        = 16;
	localparam int unsigned DIV_STEPS = CW;
	// lane latency: span stage, product stage, one stage per quotient bit, output stage
	localparam int unsigned LANE_LAT  = 2 + DIV_STEPS + 1;
	localparam int unsigned DEPTH     = LANE_LAT + 1;

	localparam logic signed [CW-1:0] HALF_TURN     = 16'sh0200;
	localparam logic signed [CW-1:0] NEG_HALF_TURN = -16'sh0200;
	localparam logic signed [CW-1:0] FULL_TURN     = 16'sh0400;

	localparam logic [1:0] OP_DELTA  = 2'd0;
	localparam logic [1:0] OP_ROT    = 2'd1;
	localparam logic [1:0] OP_ROOT   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] TYPE_ROTATE    = 2'd0;
	localparam logic [1:0] TYPE_TRANSLATE = 2'd1;
	localparam logic [1:0] TYPE_ZOOM      = 2'd2;
	localparam logic [1:0] TYPE_OTHER     = 2'd3;

	typedef enum logic [2:0] {
		MODE_ZERO,
		MODE_PASS,
		MODE_RAMP,
		MODE_ANGLE,
		MODE_LINE
	} mode_t;

	typedef struct packed {
		logic we;
		logic done;
	} ctl_t;

endpackage

`default_nettype wire

[hdl/keyframe_pose_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_unit
// Interpolates one xyz triple between two keyframes, three lanes in parallel.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready op group_type elapsed   | sink
//          | key_length prev_x/y/z next_x/y/z          |
//  out     | out_valid out_ready out_x/y/z             | source
//          | write_enable keyframe_done                |
//  cfg     | cfg_valid cfg_ready cfg_data              | sink
//
//  one transaction per cycle while the output is not stalled by out_ready
//  the restoring divider gives one quotient bit per stage per lane
//  whole pipeline advances together; it holds only when out_valid waits on out_ready
//  cfg_ready is always high; arst_n clears the valid chain and optimise_mode
`default_nettype none

module keyframe_pose_interpolator_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire                               cfg_data,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire         [1:0]                 op,
	input  wire         [1:0]                 group_type,
	input  wire         [kpi_pkg::CW-1:0]     elapsed,
	input  wire         [kpi_pkg::CW-1:0]     key_length,
	input  wire  signed [kpi_pkg::CW-1:0]     prev_x,
	input  wire  signed [kpi_pkg::CW-1:0]     prev_y,
	input  wire  signed [kpi_pkg::CW-1:0]     prev_z,
	input  wire  signed [kpi_pkg::CW-1:0]     next_x,
	input  wire  signed [kpi_pkg::CW-1:0]     next_y,
	input  wire  signed [kpi_pkg::CW-1:0]     next_z,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [kpi_pkg::CW-1:0]     out_x,
	output logic signed [kpi_pkg::CW-1:0]     out_y,
	output logic signed [kpi_pkg::CW-1:0]     out_z,
	output logic                              write_enable,
	output logic                              keyframe_done
);

	localparam int unsigned W = kpi_pkg::CW;
	localparam int unsigned D = kpi_pkg::DEPTH;

	logic optimise_mode_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			optimise_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			optimise_mode_q <= cfg_data;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// decode which rule every lane applies
	kpi_pkg::mode_t mode_c;
	kpi_pkg::ctl_t  ctl_c;
	logic           done_c;

	always_comb begin
		done_c      = elapsed >= key_length;
		ctl_c.done  = done_c;
		ctl_c.we    = 1'b1;
		mode_c      = kpi_pkg::MODE_ZERO;
		if (op == kpi_pkg::OP_UNUSED) begin
			ctl_c.we = 1'b0;
		end else if (done_c) begin
			mode_c = kpi_pkg::MODE_PASS;
		end else if (op == kpi_pkg::OP_ROOT) begin
			mode_c = kpi_pkg::MODE_RAMP;
		end else if (op == kpi_pkg::OP_ROT
				|| (group_type == kpi_pkg::TYPE_ROTATE && !optimise_mode_q)) begin
			mode_c = kpi_pkg::MODE_ANGLE;
		end else if (group_type == kpi_pkg::TYPE_TRANSLATE
				|| group_type == kpi_pkg::TYPE_ZOOM) begin
			mode_c = kpi_pkg::MODE_LINE;
		end else begin
			ctl_c.we = 1'b0;
		end
	end

	// stage 1 input registers
	kpi_pkg::mode_t      mode_s1;
	logic [W-1:0]        t_s1, len_s1;
	logic signed [W-1:0] px_s1, py_s1, pz_s1, nx_s1, ny_s1, nz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_c;
			t_s1    <= elapsed;
			len_s1  <= key_length;
			px_s1   <= prev_x;
			py_s1   <= prev_y;
			pz_s1   <= prev_z;
			nx_s1   <= next_x;
			ny_s1   <= next_y;
			nz_s1   <= next_z;
		end
	end

	// valid and flags travel beside the lanes
	logic          valid_sv [D];
	kpi_pkg::ctl_t ctl_sv   [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				valid_sv[i] <= 1'b0;
			end
		end else if (en) begin
			valid_sv[0] <= in_valid;
			for (int i = 1; i < D; i++) begin
				valid_sv[i] <= valid_sv[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sv[0] <= ctl_c;
			for (int i = 1; i < D; i++) begin
				ctl_sv[i] <= ctl_sv[i-1];
			end
		end
	end

	kpi_lane u_lane_x (
		.clk(clk), .en(en), .mode(mode_s1), .t(t_s1), .len(len_s1),
		.p(px_s1), .n(nx_s1), .result(out_x)
	);

	kpi_lane u_lane_y (
		.clk(clk), .en(en), .mode(mode_s1), .t(t_s1), .len(len_s1),
		.p(py_s1), .n(ny_s1), .result(out_y)
	);

	kpi_lane u_lane_z (
		.clk(clk), .en(en), .mode(mode_s1), .t(t_s1), .len(len_s1),
		.p(pz_s1), .n(nz_s1), .result(out_z)
	);

	// merge: lane results leave with the shared flags
	assign out_valid     = valid_sv[D-1];
	assign write_enable  = ctl_sv[D-1].we;
	assign keyframe_done = ctl_sv[D-1].done;

endmodule

`default_nettype wire

[hdl/kpi_lane.sv]
// ----------------------------------------------------------------------------
// kpi_lane
// One component lane: span select, multiply, bit-per-stage restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_lane (
	input  wire                                  clk,
	input  wire                                  en,
	input  kpi_pkg::mode_t                       mode,
	input  wire         [kpi_pkg::CW-1:0]        t,
	input  wire         [kpi_pkg::CW-1:0]        len,
	input  wire  signed [kpi_pkg::CW-1:0]        p,
	input  wire  signed [kpi_pkg::CW-1:0]        n,
	output logic signed [kpi_pkg::CW-1:0]        result
);

	localparam int unsigned W  = kpi_pkg::CW;
	localparam int unsigned NS = kpi_pkg::DIV_STEPS;

	logic signed [W-1:0] d;
	logic signed [W-1:0] base_c;
	logic signed [W-1:0] abase;
	logic signed [W-1:0] up_span;
	logic signed [W-1:0] dn_span;
	logic signed [W:0]   span_c;
	logic signed [W:0]   mag_c;
	logic                byp_c;

	always_comb begin
		d       = n - p;
		abase   = p + kpi_pkg::FULL_TURN;
		up_span = n - abase;
		dn_span = d + kpi_pkg::FULL_TURN;
		base_c  = p;
		span_c  = '0;
		byp_c   = 1'b0;
		unique case (mode)
			kpi_pkg::MODE_PASS: begin
				byp_c  = 1'b1;
				base_c = n;
			end
			kpi_pkg::MODE_RAMP: begin
				span_c = {n[W-1], n};
				base_c = '0;
			end
			kpi_pkg::MODE_LINE: begin
				span_c = $signed({n[W-1], n}) - $signed({p[W-1], p});
			end
			kpi_pkg::MODE_ANGLE: begin
				if (d == '0) begin
					byp_c  = 1'b1;
					base_c = n;
				end else if (d > kpi_pkg::HALF_TURN) begin
					// go the short way: restart from prev one turn up
					base_c = abase;
					span_c = {up_span[W-1], up_span};
				end else if (d < kpi_pkg::NEG_HALF_TURN) begin
					span_c = {dn_span[W-1], dn_span};
				end else begin
					span_c = {d[W-1], d};
				end
			end
			default: begin
				byp_c  = 1'b1;
				base_c = '0;
			end
		endcase
		mag_c = span_c[W] ? -span_c : span_c;
	end

	// stage 2: span magnitude
	logic [W-1:0]        mag_s2, t_s2, len_s2;
	logic                neg_s2, byp_s2;
	logic signed [W-1:0] base_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_c[W-1:0];
			neg_s2  <= span_c[W];
			byp_s2  <= byp_c;
			base_s2 <= base_c;
			t_s2    <= t;
			len_s2  <= len;
		end
	end

	// stage 3: product
	logic [2*W-1:0]      prod_s3;
	logic [W-1:0]        len_s3;
	logic                neg_s3, byp_s3;
	logic signed [W-1:0] base_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= mag_s2 * t_s2;
			neg_s3  <= neg_s2;
			byp_s3  <= byp_s2;
			base_s3 <= base_s2;
			len_s3  <= len_s2;
		end
	end

	// divide stages: one quotient bit each, quotient shifts into the low word
	logic [W-1:0]        rem_sd  [NS];
	logic [W-1:0]        lo_sd   [NS];
	logic [W-1:0]        len_sd  [NS];
	logic                neg_sd  [NS];
	logic                byp_sd  [NS];
	logic signed [W-1:0] base_sd [NS];

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [W-1:0]        rem_in, lo_in, len_in;
		logic                neg_in, byp_in;
		logic signed [W-1:0] base_in;
		logic [W:0]          r2, diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign rem_in  = prod_s3[2*W-1:W];
			assign lo_in   = prod_s3[W-1:0];
			assign len_in  = len_s3;
			assign neg_in  = neg_s3;
			assign byp_in  = byp_s3;
			assign base_in = base_s3;
		end else begin : g_next
			assign rem_in  = rem_sd[k-1];
			assign lo_in   = lo_sd[k-1];
			assign len_in  = len_sd[k-1];
			assign neg_in  = neg_sd[k-1];
			assign byp_in  = byp_sd[k-1];
			assign base_in = base_sd[k-1];
		end

		assign r2   = {rem_in, lo_in[W-1]};
		assign diff = r2 - {1'b0, len_in};
		assign ge   = r2 >= {1'b0, len_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k]  <= ge ? diff[W-1:0] : r2[W-1:0];
				lo_sd[k]   <= {lo_in[W-2:0], ge};
				len_sd[k]  <= len_in;
				neg_sd[k]  <= neg_in;
				byp_sd[k]  <= byp_in;
				base_sd[k] <= base_in;
			end
		end
	end

	logic [W:0] sq;
	logic [W:0] sum;

	assign sq  = neg_sd[NS-1] ? -{1'b0, lo_sd[NS-1]} : {1'b0, lo_sd[NS-1]};
	assign sum = {base_sd[NS-1][W-1], base_sd[NS-1]} + sq;

	always_ff @(posedge clk) begin
		if (en) begin
			result <= byp_sd[NS-1] ? base_sd[NS-1] : $signed(sum[W-1:0]);
		end
	end

endmodule

`default_nettype wire

[hdl/kpi_checker.sv]
// ----------------------------------------------------------------------------
// kpi_checker
// Port-level checks of the keyframe pose interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                cfg_ready,
	input wire                in_ready,
	input wire                out_valid,
	input wire                out_ready,
	input wire signed [15:0]  out_x,
	input wire signed [15:0]  out_y,
	input wire signed [15:0]  out_z,
	input wire                write_enable,
	input wire                keyframe_done
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(write_enable) && $stable(keyframe_done))
		else $error("stalled result changed");

	// input side only stalls when the result is stuck
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// no write means a zero triple
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
		else $error("nonzero triple without write");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind keyframe_pose_interpolator_unit kpi_checker u_kpi_checker (
	.clk(clk), .arst_n(arst_n), .cfg_ready(cfg_ready), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
	.out_z(out_z), .write_enable(write_enable), .keyframe_done(keyframe_done)
);

`default_nettype wire

[bench/tb_keyframe_pose_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// tb_keyframe_pose_interpolator_unit
// Self-checking bench: directed and random keyframe triples under both
// optimise_mode settings, with random idling on both channels, checked
// in order against a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
	logic [1:0]        op;
	logic [1:0]        gtype;
	logic [15:0]       el;
	logic [15:0]       len;
	logic signed [15:0] p [3];
	logic signed [15:0] n [3];
} pose_item_t;

typedef struct {
	logic [15:0] v [3];
	logic        we;
	logic        done;
} pose_out_t;

class pose_scoreboard;
	pose_out_t expected_q [$];
	bit        optimise;
	int        errors;

	function longint w16(longint v);
		logic signed [15:0] s;
		s = v[15:0];
		return s;
	endfunction

	function logic [15:0] lerp_ang(longint p, longint n, longint t, longint len);
		longint d, base, span, r;
		d = w16(n - p);
		if (d == 0)
			return n[15:0];
		if (d > kpi_pkg::HALF_TURN) begin
			base = w16(p + kpi_pkg::FULL_TURN);
			span = w16(n - base);
			r = span * t / len + base;
		end else if (d < kpi_pkg::NEG_HALF_TURN) begin
			span = w16(w16(n + kpi_pkg::FULL_TURN) - p);
			r = span * t / len + p;
		end else begin
			r = d * t / len + p;
		end
		return r[15:0];
	endfunction

	function logic [15:0] lerp_lin(longint p, longint n, longint t, longint len);
		longint r;
		if (p == n)
			return n[15:0];
		r = (n - p) * t / len + p;
		return r[15:0];
	endfunction

	function void note_input(pose_item_t it);
		pose_out_t e;
		longint t, len, r;
		t = it.el;
		len = it.len;
		e.done = (t >= len);
		e.we = 1'b0;
		for (int i = 0; i < 3; i++)
			e.v[i] = '0;
		if (it.op == kpi_pkg::OP_UNUSED) begin
			// unused op: nothing written
		end else if (e.done) begin
			for (int i = 0; i < 3; i++)
				e.v[i] = it.n[i];
			e.we = 1'b1;
		end else if (it.op == kpi_pkg::OP_ROOT) begin
			for (int i = 0; i < 3; i++) begin
				r = longint'(it.n[i]) * t / len;
				e.v[i] = r[15:0];
			end
			e.we = 1'b1;
		end else if (it.op == kpi_pkg::OP_ROT ||
				(it.gtype == kpi_pkg::TYPE_ROTATE && !optimise)) begin
			for (int i = 0; i < 3; i++)
				e.v[i] = lerp_ang(it.p[i], it.n[i], t, len);
			e.we = 1'b1;
		end else if (it.gtype == kpi_pkg::TYPE_TRANSLATE ||
				it.gtype == kpi_pkg::TYPE_ZOOM) begin
			for (int i = 0; i < 3; i++)
				e.v[i] = lerp_lin(it.p[i], it.n[i], t, len);
			e.we = 1'b1;
		end
		expected_q.push_back(e);
	endfunction

	function void check_result(pose_out_t a);
		pose_out_t e;
		string nm [3] = '{"out_x", "out_y", "out_z"};
		if (expected_q.size() == 0) begin
			$error("result with no transaction pending");
			errors++;
			return;
		end
		e = expected_q.pop_front();
		for (int i = 0; i < 3; i++)
			if (a.v[i] !== e.v[i]) begin
				$error("%s expected %h actual %h", nm[i], e.v[i], a.v[i]);
				errors++;
			end
		if (a.we !== e.we) begin
			$error("write_enable expected %b actual %b", e.we, a.we);
			errors++;
		end
		if (a.done !== e.done) begin
			$error("keyframe_done expected %b actual %b", e.done, a.done);
			errors++;
		end
	endfunction
endclass

module tb_keyframe_pose_interpolator_unit;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] op = '0;
	logic [1:0] group_type = '0;
	logic [15:0] elapsed = '0;
	logic [15:0] key_length = '0;
	logic signed [15:0] prev_x = '0, prev_y = '0, prev_z = '0;
	logic signed [15:0] next_x = '0, next_y = '0, next_z = '0;
	logic out_ready = 1'b0;
	logic cfg_ready, in_ready, out_valid, write_enable, keyframe_done;
	logic signed [15:0] out_x, out_y, out_z;
	bit quiet = 1'b0;
	pose_scoreboard sb = new();

	keyframe_pose_interpolator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .group_type(group_type), .elapsed(elapsed), .key_length(key_length),
		.prev_x(prev_x), .prev_y(prev_y), .prev_z(prev_z),
		.next_x(next_x), .next_y(next_y), .next_z(next_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.write_enable(write_enable), .keyframe_done(keyframe_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("keyframe_pose_interpolator_unit test failed");
		$finish;
	end

	// result side: random stall bursts
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pose_out_t a;
		if (arst_n && out_valid && out_ready) begin
			a.v[0] = out_x;
			a.v[1] = out_y;
			a.v[2] = out_z;
			a.we = write_enable;
			a.done = keyframe_done;
			sb.check_result(a);
		end
	end

	task automatic send_pose(pose_item_t it);
		in_valid <= 1'b1;
		op <= it.op;
		group_type <= it.gtype;
		elapsed <= it.el;
		key_length <= it.len;
		prev_x <= it.p[0];
		prev_y <= it.p[1];
		prev_z <= it.p[2];
		next_x <= it.n[0];
		next_y <= it.n[1];
		next_z <= it.n[2];
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		sb.optimise = m;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed(logic [1:0] o, logic [1:0] g, logic [15:0] e, logic [15:0] l,
			logic [15:0] px, logic [15:0] py, logic [15:0] pz,
			logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		pose_item_t it;
		it.op = o;
		it.gtype = g;
		it.el = e;
		it.len = l;
		it.p[0] = px;
		it.p[1] = py;
		it.p[2] = pz;
		it.n[0] = nx;
		it.n[1] = ny;
		it.n[2] = nz;
		send_pose(it);
	endtask

	function automatic logic [15:0] rand_comp();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic pose_item_t rand_pose();
		pose_item_t it;
		int sel;
		it.op = ($urandom_range(0, 15) == 0) ? kpi_pkg::OP_UNUSED : 2'($urandom_range(0, 2));
		it.gtype = 2'($urandom_range(0, 3));
		sel = $urandom_range(0, 9);
		if (sel == 0)
			it.len = rand_comp();
		else if (sel == 1)
			it.len = 16'hffff - 16'($urandom_range(0, 3));
		else
			it.len = 16'($urandom_range(0, 2000));
		if (it.len != 0 && $urandom_range(0, 4) != 0)
			it.el = 16'($urandom_range(0, it.len - 1));
		else
			it.el = rand_comp();
		for (int i = 0; i < 3; i++) begin
			it.p[i] = rand_comp();
			sel = $urandom_range(0, 5);
			// near neighbors hit the wrap boundaries, equal ones the pass-through
			if (sel == 0)
				it.n[i] = it.p[i];
			else if (sel <= 3)
				it.n[i] = it.p[i] + 16'($signed($urandom_range(0, 1600)) - 800);
			else
				it.n[i] = rand_comp();
		end
		return it;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_mode(1'b0);

		// keyframe reached, zero length and full length; unused op reached and not reached
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ROTATE, 0, 0, 1, 2, 3, 16'h8000, 16'h7fff, 0);
		directed(kpi_pkg::OP_ROT, kpi_pkg::TYPE_OTHER, 16'hffff, 16'hffff, 5, 5, 5,
			16'hffff, 1, 2);
		directed(kpi_pkg::OP_ROOT, kpi_pkg::TYPE_OTHER, 16'hffff, 16'd100, 5, 5, 5, 9, 8, 7);
		directed(kpi_pkg::OP_UNUSED, kpi_pkg::TYPE_ZOOM, 16'd50, 16'd50, 1, 1, 1, 4, 4, 4);
		directed(kpi_pkg::OP_UNUSED, kpi_pkg::TYPE_ROTATE, 16'd10, 16'd50, 1, 1, 1, 4, 4, 4);
		// wide spans in a long keyframe, near its end, at its start and midway
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_TRANSLATE, 16'hfffe, 16'hffff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ZOOM, 0, 16'hffff,
			16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 0);
		directed(kpi_pkg::OP_ROOT, kpi_pkg::TYPE_ROTATE, 16'h7fff, 16'hffff,
			16'h1234, 0, 0, 16'h8000, 16'h7fff, 16'hffff);
		// angle wrap both ways and exactly at the half turn
		directed(kpi_pkg::OP_ROT, kpi_pkg::TYPE_TRANSLATE, 16'd3, 16'd7,
			16'h0000, 16'h0100, 16'hff00, 16'h0201, 16'hfe00, 16'h0100);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ROTATE, 16'd1, 16'd3,
			16'h0000, 16'h0000, 16'h7f00, 16'h0200, 16'hfe00, 16'h8100);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ROTATE, 16'd1, 16'd3,
			16'h0000, 16'h0000, 16'h0000, 16'hfdff, 16'h0201, 16'h03ff);
		directed(kpi_pkg::OP_ROT, kpi_pkg::TYPE_ROTATE, 16'd2, 16'd5,
			16'h8000, 16'h7fff, 16'h1000, 16'h7fff, 16'h8000, 16'h1000);
		// other group type, translate with equal parts
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_OTHER, 16'd2, 16'd9, 1, 2, 3, 7, 8, 9);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_TRANSLATE, 16'd4, 16'd9,
			16'd100, 16'hffff, 16'd3, 16'd100, 16'h0000, 16'hfff0);
		drain();

		write_mode(1'b1);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ROTATE, 16'd4, 16'd9, 1, 2, 3, 70, 80, 90);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ROTATE, 16'd9, 16'd9, 1, 2, 3, 70, 80, 90);
		directed(kpi_pkg::OP_ROT, kpi_pkg::TYPE_ROTATE, 16'd4, 16'd9, 1, 2, 3, 16'h0300, 80, 90);
		directed(kpi_pkg::OP_DELTA, kpi_pkg::TYPE_ZOOM, 16'd4, 16'd9, 1, 2, 3, 70, 80, 90);
		for (int k = 0; k < 500; k++)
			send_pose(rand_pose());
		drain();

		write_mode(1'b0);
		for (int k = 0; k < 500; k++)
			send_pose(rand_pose());
		drain();

		write_mode(1'b1);
		for (int k = 0; k < 530; k++) begin
			if (k == 380)
				quiet = 1'b1;
			send_pose(rand_pose());
		end
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("keyframe_pose_interpolator_unit test passed");
		else
			$display("keyframe_pose_interpolator_unit test failed");
		$finish;
	end
endmodule
